// ===== hw/rtl/gcprm_pkg.sv =====
// Shared types and constants for the gain, clip and peak/RMS meter.
// Used by every module in hw/rtl; no dependencies of its own.
package gcprm_pkg;

    localparam int SAMPLE_BITS           = 24;
    localparam int GAIN_BITS             = 16;
    localparam int GAIN_FRAC_BITS        = 14;
    localparam int MAX_BLOCK_SAMPLES_DEF = 8192;
    localparam int FIFO_DEPTH            = 4;

    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic [GAIN_BITS-1:0] GAIN_MAX   = GAIN_BITS'(2 << GAIN_FRAC_BITS);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] scaled_sample;
        logic                          block_done;
        logic [SAMPLE_BITS-1:0]        block_peak;
        logic [SAMPLE_BITS-1:0]        block_rms;
    } t_out_beat;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] scaled;
        logic [SAMPLE_BITS-1:0]        mag;
        logic [2*SAMPLE_BITS-1:0]      sq;
        logic                          block_end;
    } t_meas;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_back_state;

endpackage

// ===== hw/rtl/gcprm_front.sv =====
// Front part: gain register, gain multiply, floor/saturate, magnitude and square.
// Depends on gcprm_pkg.
module gcprm_front
    import gcprm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GAIN_BITS-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_push,
    input  logic                 i_full,
    output t_meas                o_push_data
);

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic signed [PW-1:0] QMAX = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] QMIN = -QMAX - PW'(1);

    logic [GAIN_BITS-1:0]          r_gain;
    logic                          r_s1_valid, r_s2_valid, r_s3_valid;
    logic signed [PW-1:0]          r_s1_prod;
    logic                          r_s1_end, r_s2_end;
    logic signed [SAMPLE_BITS-1:0] r_s2_scaled;
    logic [SAMPLE_BITS-1:0]        r_s2_mag;
    t_meas                         r_s3;

    logic                          w_adv;
    logic signed [PW-1:0]          w_q;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic [SAMPLE_BITS-1:0]        w_mag;

    assign w_adv      = !r_s3_valid || !i_full;
    assign o_in_stall = !w_adv;
    assign o_push     = r_s3_valid;
    assign o_push_data = r_s3;

    // Arithmetic shift right is a floor division by the gain scale.
    assign w_q = r_s1_prod >>> GAIN_FRAC_BITS;

    always_comb begin
        if (w_q > QMAX) begin
            w_sat = SAMPLE_BITS'(QMAX);
        end else if (w_q < QMIN) begin
            w_sat = SAMPLE_BITS'(QMIN);
        end else begin
            w_sat = SAMPLE_BITS'(w_q);
        end
    end

    // Negative full scale wraps to 2^(SAMPLE_BITS-1) as an unsigned magnitude.
    assign w_mag = w_sat[SAMPLE_BITS-1] ? (~w_sat + 1'b1) : w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_UNITY;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= (i_cfg_wdata > GAIN_MAX) ? GAIN_MAX : i_cfg_wdata;
            end
            if (w_adv) begin
                r_s1_valid <= i_in_valid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod    <= i_in_data.sample * $signed({1'b0, r_gain});
            r_s1_end     <= i_in_data.block_end;
            r_s2_scaled  <= w_sat;
            r_s2_mag     <= w_mag;
            r_s2_end     <= r_s1_end;
            r_s3.scaled    <= r_s2_scaled;
            r_s3.mag       <= r_s2_mag;
            r_s3.sq        <= r_s2_mag * r_s2_mag;
            r_s3.block_end <= r_s2_end;
        end
    end

endmodule

// ===== hw/rtl/gcprm_fifo.sv =====
// Short queue of classified samples between the front and back parts.
// Depends on gcprm_pkg.
module gcprm_fifo
    import gcprm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_meas i_push_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_meas o_rd_data
);

    localparam int AW = $clog2(FIFO_DEPTH);

    t_meas         r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_count;
    logic          w_wr, w_rd;

    assign o_full    = (r_count == (AW+1)'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/gcprm_back.sv =====
// Back part: block accumulators, serial divider, serial square root, output register.
// Depends on gcprm_pkg.
module gcprm_back
    import gcprm_pkg::*;
#(
    parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_meas     i_entry,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int CW = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int EW = 2 * SB - 1 + $clog2(MAX_BLOCK_SAMPLES);
    localparam int MW = 2 * SB;
    localparam int RW = SB + 2;
    localparam int SW = $clog2(EW + 1);

    t_back_state      r_state, n_state;
    logic [SB-1:0]    r_peak;
    logic [EW-1:0]    r_energy;
    logic [CW-1:0]    r_count;
    logic signed [SB-1:0] r_hold_scaled;
    logic [SB-1:0]    r_hold_peak;
    logic [SW-1:0]    r_step;
    logic [EW-1:0]    r_dq;
    logic [CW-1:0]    r_drem;
    logic [CW-1:0]    r_dcount;
    logic [MW-1:0]    r_sq_val;
    logic [RW-1:0]    r_sq_rem;
    logic [SB-1:0]    r_root;
    t_out_beat        r_out;
    logic             r_out_valid;

    logic             w_out_free, w_end, w_ld_done;
    logic [CW-1:0]    w_count_inc;
    logic [SB-1:0]    w_peak_new;
    logic [EW-1:0]    w_energy_new;
    logic [CW:0]      w_div_shift;
    logic             w_div_ge;
    logic [CW-1:0]    w_drem_next;
    logic [EW-1:0]    w_dq_next;
    logic [RW-1:0]    w_sq_shift, w_sq_trial, w_sq_rem_next;
    logic             w_sq_ge;
    logic [SB-1:0]    w_root_next;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_count_inc  = r_count + 1'b1;
    // A block that reaches the sample limit closes on this beat.
    assign w_end        = i_entry.block_end || (w_count_inc == CW'(MAX_BLOCK_SAMPLES));
    assign w_peak_new   = (i_entry.mag > r_peak) ? i_entry.mag : r_peak;
    assign w_energy_new = r_energy + EW'(i_entry.sq);

    // Restoring divider step: one quotient bit a cycle.
    assign w_div_shift = {r_drem, r_dq[EW-1]};
    assign w_div_ge    = (w_div_shift >= {1'b0, r_dcount});
    assign w_drem_next = w_div_ge ? CW'(w_div_shift - {1'b0, r_dcount}) : CW'(w_div_shift);
    assign w_dq_next   = {r_dq[EW-2:0], w_div_ge};

    // Digit-by-digit square root step: one root bit a cycle.
    assign w_sq_shift    = {r_sq_rem[RW-3:0], r_sq_val[MW-1 -: 2]};
    assign w_sq_trial    = {r_root, 2'b01};
    assign w_sq_ge       = (w_sq_shift >= w_sq_trial);
    assign w_sq_rem_next = w_sq_ge ? (w_sq_shift - w_sq_trial) : w_sq_shift;
    assign w_root_next   = {r_root[SB-2:0], w_sq_ge};

    always_comb begin
        o_pop     = 1'b0;
        w_ld_done = 1'b0;
        unique case (r_state)
            ST_ACC:  o_pop     = !i_empty && w_out_free;
            ST_OUT:  w_ld_done = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (o_pop && w_end) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == SW'(1)) n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_step == SW'(1)) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) n_state = ST_ACC;
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_energy    <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if ((o_pop && !w_end) || w_ld_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (w_end) begin
                    r_peak   <= '0;
                    r_energy <= '0;
                    r_count  <= '0;
                end else begin
                    r_peak   <= w_peak_new;
                    r_energy <= w_energy_new;
                    r_count  <= w_count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_ACC: begin
                if (o_pop) begin
                    if (w_end) begin
                        r_hold_scaled <= i_entry.scaled;
                        r_hold_peak   <= w_peak_new;
                        r_dq          <= w_energy_new;
                        r_drem        <= '0;
                        r_dcount      <= w_count_inc;
                        r_step        <= SW'(EW);
                    end else begin
                        r_out <= '{scaled_sample: i_entry.scaled, block_done: 1'b0,
                                   block_peak: '0, block_rms: '0};
                    end
                end
            end
            ST_DIV: begin
                r_dq   <= w_dq_next;
                r_drem <= w_drem_next;
                if (r_step == SW'(1)) begin
                    r_sq_val <= w_dq_next[MW-1:0];
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_step   <= SW'(SB);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_SQRT: begin
                r_sq_val <= r_sq_val << 2;
                r_sq_rem <= w_sq_rem_next;
                r_root   <= w_root_next;
                r_step   <= r_step - 1'b1;
            end
            ST_OUT: begin
                if (w_ld_done) begin
                    r_out <= '{scaled_sample: r_hold_scaled, block_done: 1'b1,
                               block_peak: r_hold_peak, block_rms: r_root};
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/gain_clip_peak_rms_meter_core.sv =====
// Gain, clip and block peak/RMS meter. A result beat for an input beat that does not
// close a block passes the front pipeline, the queue and the output register; a closing
// beat also waits for the serial divider and square root before its result is posted.
// Throughput: one beat per cycle inside a block while the output is not stalled; the back holds off new beats while the
// divider and root run, with up to 3 + FIFO_DEPTH beats taken in meanwhile.
// Reset (synchronous, active low) sets gain to unity and clears the meters and queues.
module gain_clip_peak_rms_meter_core
    import gcprm_pkg::*;
#(
    parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GAIN_BITS-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data
);

    // Front -> queue -> back. The front runs a three-stage multiply/saturate/square
    // pipeline and keeps moving as long as the queue has room; the back drains the
    // queue, updates peak, energy and count, and on a closing beat runs the mean
    // division and the square root one bit per cycle before posting the meters.
    logic  w_push, w_full, w_pop, w_empty;
    t_meas w_push_data, w_rd_data;

    gcprm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (w_push),
        .i_full      (w_full),
        .o_push_data (w_push_data)
    );

    // Hold classified beats so the back can run its long block-close sequence
    // without stalling the front immediately.
    gcprm_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_rd_data   (w_rd_data)
    );

    // Meters and the output register; one result beat per input beat, in order.
    gcprm_back #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_entry     (w_rd_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
